FILE: design/obst_pkg.sv
// Shared types and codes for the ordered byte set table.
// Operation codes, status codes, field widths and the sequencer state type.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package obst_pkg;

  localparam int unsigned KIND_W   = 2;
  localparam int unsigned VALUE_W  = 8;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned COUNT_W  = 5;
  localparam int unsigned CAP_W    = 5;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  typedef enum logic [KIND_W-1:0] {
    KIND_INSERT = 2'd0,
    KIND_QUERY  = 2'd1,
    KIND_REMOVE = 2'd2,
    KIND_SPARE  = 2'd3
  } kind_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK      = 2'd0,
    STAT_DUP     = 2'd1,
    STAT_ABSENT  = 2'd2,
    STAT_FULL    = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SCAN   = 4'b0010,
    ST_SHIFT  = 4'b0100,
    ST_RESULT = 4'b1000
  } state_e;

endpackage

`default_nettype wire

FILE: design/obst_ram.sv
// Entry store of the ordered byte set table: one write port, one read port,
// read data registered. No package dependencies.
`timescale 1ns / 1ps
`default_nettype none

module obst_ram #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = 4,
  parameter int unsigned DW    = 8
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire logic [DW-1:0] wdata_i,
  input  wire logic [AW-1:0] raddr_i,
  output logic      [DW-1:0] rdata_o
);

  logic [DW-1:0] mem_q [DEPTH];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: design/ordered_byte_set_table.sv
// Ordered byte set table: a set of distinct bytes kept in insertion order.
// Request channel in_*: valid/stall, fields kind and value. Result channel
// out_*: valid/stall, fields status, found and count, one result per request.
// Configuration: cfg_we_i writes cfg_wdata_i into the capacity register
// (reset 16); the user writes only while the block is idle (not enforced).
// One request at a time. A single compare unit walks the entry store one
// entry per cycle from the front until it hits or reaches the end; a remove
// then moves each later entry down one place, one entry per cycle, through
// the same store port. The result goes to the output register once the walk
// ends (at least one compare even on an empty table), or once the move ends
// for a remove that hits, and the output register is free. The sequencer
// returns to idle as the result is loaded into the output register.
// in_stall_o is low only while the sequencer is idle. The result sits in an
// output register; a stalled result holds, and the next request is accepted
// meanwhile, its result waiting until the register is taken.
// Reset clears the count, capacity goes to 16 and the output is empty; the
// entry store is not cleared, as only entries below the count are used.
// Depends on obst_pkg and obst_ram.
`timescale 1ns / 1ps
`default_nettype none

module ordered_byte_set_table #(
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [obst_pkg::CAP_W-1:0]     cfg_wdata_i,
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire logic [obst_pkg::KIND_W-1:0]    in_kind_i,
  input  wire logic [obst_pkg::VALUE_W-1:0]   in_value_i,
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output logic      [obst_pkg::STATUS_W-1:0]  out_status_o,
  output logic                                out_found_o,
  output logic      [obst_pkg::COUNT_W-1:0]   out_count_o
);

  localparam int unsigned IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned LW = (CW > obst_pkg::CAP_W) ? CW : obst_pkg::CAP_W;

  obst_pkg::state_e                   state_q, state_d;
  logic [obst_pkg::CAP_W-1:0]         cap_q;
  logic [CW-1:0]                      used_q, used_d;
  logic [IW-1:0]                      ptr_q, ptr_d;
  obst_pkg::kind_e                    kind_q;
  logic [obst_pkg::VALUE_W-1:0]       value_q;
  obst_pkg::status_e                  stat_q, stat_d;
  logic                               hit_q, hit_d;

  logic                               out_valid_q;
  logic [obst_pkg::STATUS_W-1:0]      out_status_q;
  logic                               out_found_q;
  logic [obst_pkg::COUNT_W-1:0]       out_count_q;

  logic                               accept;
  logic                               load_out;
  logic [obst_pkg::VALUE_W-1:0]       rdata;
  logic                               cmp_hit;
  logic                               scan_last;
  logic                               is_full;
  logic [CW-1:0]                      next_pos;
  logic                               mem_we;
  logic [IW-1:0]                      mem_waddr;
  logic [obst_pkg::VALUE_W-1:0]       mem_wdata;
  logic [IW-1:0]                      mem_raddr;

  assign accept    = in_valid_i && (state_q == obst_pkg::ST_IDLE);
  assign load_out  = (state_q == obst_pkg::ST_RESULT) && (!out_valid_q || !out_stall_i);
  assign next_pos  = CW'(ptr_q) + CW'(1);
  assign cmp_hit   = (used_q != '0) && (rdata == value_q);
  assign scan_last = (used_q == '0) || (next_pos == used_q);
  assign is_full   = (LW'(used_q) >= LW'(cap_q)) || (used_q == CW'(DEPTH));

  always_comb begin
    state_d   = state_q;
    used_d    = used_q;
    ptr_d     = ptr_q;
    stat_d    = stat_q;
    hit_d     = hit_q;
    mem_we    = 1'b0;
    mem_waddr = ptr_q;
    mem_wdata = rdata;
    unique case (state_q)
      obst_pkg::ST_IDLE: begin
        if (accept) begin
          state_d = obst_pkg::ST_SCAN;
          ptr_d   = '0;
          stat_d  = obst_pkg::STAT_OK;
          hit_d   = 1'b0;
        end
      end
      obst_pkg::ST_SCAN: begin
        if (cmp_hit) begin
          hit_d = 1'b1;
          unique case (kind_q)
            obst_pkg::KIND_INSERT: begin
              stat_d  = obst_pkg::STAT_DUP;
              state_d = obst_pkg::ST_RESULT;
            end
            obst_pkg::KIND_REMOVE: state_d = obst_pkg::ST_SHIFT;
            default:               state_d = obst_pkg::ST_RESULT;
          endcase
        end else if (scan_last) begin
          state_d = obst_pkg::ST_RESULT;
          unique case (kind_q)
            obst_pkg::KIND_INSERT: begin
              if (is_full) begin
                stat_d = obst_pkg::STAT_FULL;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = used_q[IW-1:0];
                mem_wdata = value_q;
                used_d    = used_q + CW'(1);
              end
            end
            obst_pkg::KIND_REMOVE: stat_d = obst_pkg::STAT_ABSENT;
            default:               stat_d = obst_pkg::STAT_OK;
          endcase
        end else begin
          ptr_d = ptr_q + IW'(1);
        end
      end
      obst_pkg::ST_SHIFT: begin
        // move the following entry down over this one until the end
        if (next_pos < used_q) begin
          mem_we = 1'b1;
          ptr_d  = ptr_q + IW'(1);
        end else begin
          used_d  = used_q - CW'(1);
          state_d = obst_pkg::ST_RESULT;
        end
      end
      obst_pkg::ST_RESULT: begin
        if (load_out) begin
          state_d = obst_pkg::ST_IDLE;
        end
      end
      default: state_d = obst_pkg::ST_IDLE;
    endcase
  end

  // fetch one ahead so the data for the next compare or move is ready in time
  assign mem_raddr = (state_d == obst_pkg::ST_SHIFT) ? (ptr_d + IW'(1)) : ptr_d;

  obst_ram #(
    .DEPTH (DEPTH),
    .AW    (IW),
    .DW    (obst_pkg::VALUE_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= obst_pkg::ST_IDLE;
      used_q      <= '0;
      cap_q       <= obst_pkg::CAP_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      used_q  <= used_d;
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q  <= ptr_d;
    stat_q <= stat_d;
    hit_q  <= hit_d;
    if (accept) begin
      kind_q  <= obst_pkg::kind_e'(in_kind_i);
      value_q <= in_value_i;
    end
    if (load_out) begin
      out_status_q <= stat_q;
      out_found_q  <= hit_q;
      out_count_q  <= obst_pkg::COUNT_W'(used_q);
    end
  end

  assign in_stall_o   = (state_q != obst_pkg::ST_IDLE);
  assign out_valid_o  = out_valid_q;
  assign out_status_o = out_status_q;
  assign out_found_o  = out_found_q;
  assign out_count_o  = out_count_q;

  a_used_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= CW'(DEPTH))
    else $error("entry count above depth");

  a_shift_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == obst_pkg::ST_SHIFT) |-> (CW'(ptr_q) < used_q))
    else $error("shift pointer beyond held entries");

  a_dup_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_status_o == obst_pkg::STAT_DUP)) |-> out_found_o)
    else $error("duplicate reported without a hit");

  a_absent_not_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_status_o == obst_pkg::STAT_ABSENT)) |-> !out_found_o)
    else $error("not-present reported with a hit");

  a_result_waits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == obst_pkg::ST_RESULT) && out_valid_o && out_stall_i)
      |=> (state_q == obst_pkg::ST_RESULT))
    else $error("result dropped while output stalled");

endmodule

`default_nettype wire

FILE: verif/obst_checker.sv
// Result checker for the ordered byte set table: watches the request, result
// and capacity ports, keeps its own copy of the set and compares every result.
// Depends on obst_pkg.
`timescale 1ns / 1ps

module obst_checker (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [obst_pkg::CAP_W-1:0]    cfg_wdata_i,
  input  wire logic                          in_valid_i,
  input  wire logic                          in_stall_i,
  input  wire logic [obst_pkg::KIND_W-1:0]   in_kind_i,
  input  wire logic [obst_pkg::VALUE_W-1:0]  in_value_i,
  input  wire logic                          out_valid_i,
  input  wire logic                          out_stall_i,
  input  wire logic [obst_pkg::STATUS_W-1:0] out_status_i,
  input  wire logic                          out_found_i,
  input  wire logic [obst_pkg::COUNT_W-1:0]  out_count_i,
  output int                                 mismatches_o,
  output int                                 waiting_o
);

  localparam int unsigned SLOTS = 16;

  typedef struct packed {
    obst_pkg::status_e                status;
    logic                             found;
    logic [obst_pkg::COUNT_W-1:0]     count;
  } set_reply_t;

  logic [obst_pkg::VALUE_W-1:0] held [SLOTS];
  int unsigned                  held_count;
  logic [obst_pkg::CAP_W-1:0]   cap_reg;
  set_reply_t                   reply_q [$];
  int                           mismatches = 0;

  assign mismatches_o = mismatches;

  task automatic report_mismatch(string what, int got, int want);
    if (mismatches < 40) begin
      $display("%0t ns: mismatch on %s: got %0d, want %0d", $time, what, got, want);
    end
    mismatches++;
  endtask

  // Apply one request to the shadow set and return the result it gives.
  function automatic set_reply_t apply_request(obst_pkg::kind_e op,
                                               logic [obst_pkg::VALUE_W-1:0] val);
    set_reply_t  r;
    int unsigned hit_at;
    int unsigned limit;
    logic        hit;
    hit    = 1'b0;
    hit_at = 0;
    limit  = (cap_reg > SLOTS) ? SLOTS : cap_reg;
    for (int i = 0; i < held_count; i++) begin
      if (!hit && held[i] == val) begin
        hit    = 1'b1;
        hit_at = i;
      end
    end
    r.status = obst_pkg::STAT_OK;
    case (op)
      obst_pkg::KIND_INSERT: begin
        // a duplicate wins over full
        if (hit) begin
          r.status = obst_pkg::STAT_DUP;
        end else if (held_count >= limit) begin
          r.status = obst_pkg::STAT_FULL;
        end else begin
          held[held_count] = val;
          held_count++;
        end
      end
      obst_pkg::KIND_REMOVE: begin
        if (!hit) begin
          r.status = obst_pkg::STAT_ABSENT;
        end else begin
          // close the gap, keeping insertion order
          for (int i = hit_at; i + 1 < held_count; i++) held[i] = held[i + 1];
          held_count--;
        end
      end
      default: ;
    endcase
    r.found = hit;
    r.count = held_count[obst_pkg::COUNT_W-1:0];
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    set_reply_t want;
    if (!rst_ni) begin
      held_count = 0;
      cap_reg    = obst_pkg::CAP_RESET;
      reply_q.delete();
      waiting_o <= 0;
    end else begin
      if (cfg_we_i) cap_reg = cfg_wdata_i;
      if (out_valid_i && !out_stall_i) begin
        if (reply_q.size() == 0) begin
          report_mismatch("unexpected result status", out_status_i, -1);
        end else begin
          want = reply_q.pop_front();
          if (out_status_i !== want.status) report_mismatch("status", out_status_i, want.status);
          if (out_found_i !== want.found) report_mismatch("found", out_found_i, want.found);
          if (out_count_i !== want.count) report_mismatch("count", out_count_i, want.count);
        end
      end
      if (in_valid_i && !in_stall_i) begin
        reply_q.push_back(apply_request(obst_pkg::kind_e'(in_kind_i), in_value_i));
      end
      waiting_o <= reply_q.size();
    end
  end

endmodule

FILE: verif/tb_top.sv
// Testbench top for the ordered byte set table: drives requests, capacity
// writes and result stalls, and gives the verdict from the checker's count.
// Depends on obst_pkg, ordered_byte_set_table and obst_checker.
`timescale 1ns / 1ps

module tb_top;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          cfg_we = 1'b0;
  logic [obst_pkg::CAP_W-1:0]    cfg_wdata = '0;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  logic [obst_pkg::KIND_W-1:0]   in_kind = obst_pkg::KIND_QUERY;
  logic [obst_pkg::VALUE_W-1:0]  in_value = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic [obst_pkg::STATUS_W-1:0] out_status;
  logic                          out_found;
  logic [obst_pkg::COUNT_W-1:0]  out_count;
  int                            mismatches;
  int                            waiting;
  bit                            idling_on = 1'b1;

  ordered_byte_set_table #(.DEPTH(16)) dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_kind_i   (in_kind),
    .in_value_i  (in_value),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_status_o(out_status),
    .out_found_o (out_found),
    .out_count_o (out_count)
  );

  obst_checker u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .in_kind_i   (in_kind),
    .in_value_i  (in_value),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .out_status_i(out_status),
    .out_found_i (out_found),
    .out_count_i (out_count),
    .mismatches_o(mismatches),
    .waiting_o   (waiting)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Stall the result side in random bursts.
  initial begin
    forever begin
      @(posedge clk);
      if (idling_on && $urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 13)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  task automatic send_request(obst_pkg::kind_e op, logic [obst_pkg::VALUE_W-1:0] val);
    if (idling_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_kind  <= op;
    in_value <= val;
    do @(posedge clk); while (in_stall);
  endtask

  // Hold off new requests until every expected result has come back.
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (waiting != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_capacity(logic [obst_pkg::CAP_W-1:0] cap);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_wdata <= cap;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Values mostly come from a small window so that hits, duplicates and a
  // full table turn up often.
  task automatic run_phase(int n, int fill_pct);
    logic [obst_pkg::VALUE_W-1:0] base;
    logic [obst_pkg::VALUE_W-1:0] val;
    obst_pkg::kind_e              op;
    int                           roll;
    base = obst_pkg::VALUE_W'($urandom_range(0, 255));
    for (int i = 0; i < n; i++) begin
      roll = $urandom_range(0, 99);
      if (roll < 4) op = obst_pkg::KIND_SPARE;
      else if (roll < 14) op = obst_pkg::KIND_QUERY;
      else if (roll < 14 + fill_pct * 86 / 100) op = obst_pkg::KIND_INSERT;
      else op = obst_pkg::KIND_REMOVE;
      if ($urandom_range(0, 7) == 0) val = obst_pkg::VALUE_W'($urandom_range(0, 255));
      else val = base + obst_pkg::VALUE_W'($urandom_range(0, 23));
      send_request(op, val);
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // empty table, both ends of the value range, front and back removal
    send_request(obst_pkg::KIND_QUERY, 8'h00);
    send_request(obst_pkg::KIND_REMOVE, 8'h00);
    send_request(obst_pkg::KIND_SPARE, 8'hFF);
    send_request(obst_pkg::KIND_INSERT, 8'h00);
    send_request(obst_pkg::KIND_INSERT, 8'hFF);
    send_request(obst_pkg::KIND_INSERT, 8'h00);
    send_request(obst_pkg::KIND_INSERT, 8'hAA);
    send_request(obst_pkg::KIND_INSERT, 8'h55);
    send_request(obst_pkg::KIND_QUERY, 8'hFF);
    send_request(obst_pkg::KIND_SPARE, 8'hAA);
    send_request(obst_pkg::KIND_REMOVE, 8'h00);
    send_request(obst_pkg::KIND_REMOVE, 8'h55);
    send_request(obst_pkg::KIND_REMOVE, 8'h00);
    send_request(obst_pkg::KIND_QUERY, 8'h00);

    // small capacity: full, duplicate while full, middle removal
    set_capacity(5'd3);
    send_request(obst_pkg::KIND_INSERT, 8'h01);
    send_request(obst_pkg::KIND_INSERT, 8'h02);
    send_request(obst_pkg::KIND_INSERT, 8'hFF);
    send_request(obst_pkg::KIND_REMOVE, 8'hAA);
    send_request(obst_pkg::KIND_INSERT, 8'h02);

    // capacity dropped below the count
    set_capacity(5'd1);
    send_request(obst_pkg::KIND_INSERT, 8'h07);
    send_request(obst_pkg::KIND_REMOVE, 8'hFF);
    send_request(obst_pkg::KIND_INSERT, 8'h07);
    send_request(obst_pkg::KIND_REMOVE, 8'h01);
    send_request(obst_pkg::KIND_REMOVE, 8'h02);
    send_request(obst_pkg::KIND_INSERT, 8'h07);

    set_capacity(5'd0);
    send_request(obst_pkg::KIND_INSERT, 8'h09);
    send_request(obst_pkg::KIND_QUERY, 8'h07);

    set_capacity(5'd16); run_phase(170, 70);
    set_capacity(5'd31); run_phase(170, 60);
    set_capacity(5'd0);  run_phase(170, 50);
    set_capacity(5'd1);  run_phase(170, 50);
    idling_on = 1'b0;
    set_capacity(5'd16); run_phase(170, 30);
    idling_on = 1'b1;
    set_capacity(5'd8);  run_phase(170, 65);
    set_capacity(5'd17); run_phase(170, 55);
    set_capacity(5'd2);  run_phase(170, 50);
    set_capacity(5'($urandom_range(0, 31))); run_phase(170, 50);
    idling_on = 1'b0;
    set_capacity(5'd16); run_phase(170, 50);

    drain_results();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && waiting == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

FILE: ordered_byte_set_table.f
design/obst_pkg.sv
design/obst_ram.sv
design/ordered_byte_set_table.sv
verif/obst_checker.sv
verif/tb_top.sv
